// ----- design/hsv2rgb_pkg.sv -----
// Shared types, constants and arithmetic helpers for the HSV to RGB pipeline.
// No dependencies; used by every hsv2rgb module.
package hsv2rgb_pkg;

  localparam int unsigned STAGES = 7;

  localparam logic [7:0]  FULL_SCALE  = 8'd255;
  localparam logic [15:0] FULL_SQUARE = 16'd65025;

  // Channel permutation per hue sector; hue 255 folds into the red sector.
  typedef enum logic [2:0] {
    SEC_VTP,
    SEC_QVP,
    SEC_PVT,
    SEC_PQV,
    SEC_TPV,
    SEC_VPQ
  } sector_t;

  typedef struct packed {
    logic [STAGES-1:0] adv;
  } pipe_ctl_t;

  typedef struct packed {
    sector_t    sector;
    logic [7:0] rm;
    logic [7:0] sat;
    logic [7:0] val;
  } sec_t;

  typedef struct packed {
    sector_t    sector;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } lvl_t;

  // floor(x / 255): shift-add estimate is never high and at most one low.
  function automatic logic [16:0] div255(input logic [23:0] x);
    logic [24:0] s;
    logic [16:0] e;
    logic [24:0] m;
    logic [24:0] r;
    s = {1'b0, x} + {9'b0, x[23:8]} + {17'b0, x[23:16]};
    e = s[24:8];
    m = {e, 8'b0} - {8'b0, e};
    r = {1'b0, x} - m;
    if (r >= 25'(FULL_SCALE)) begin
      e = e + 17'd1;
    end
    return e;
  endfunction

endpackage

// ----- design/hsv2rgb_sector.sv -----
// Stage 1: splits hue*6 into sector and remainder by threshold compares.
// Depends on hsv2rgb_pkg.
module hsv2rgb_sector (
  input  logic                  clk,
  input  hsv2rgb_pkg::pipe_ctl_t ctl,
  input  logic [7:0]            hue,
  input  logic [7:0]            saturation,
  input  logic [7:0]            brightness,
  output hsv2rgb_pkg::sec_t     sec_r
);
  import hsv2rgb_pkg::*;

  logic [10:0] scaled;
  sec_t        sec_nxt;

  always_comb begin
    scaled = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    sec_nxt.sat = saturation;
    sec_nxt.val = brightness;
    if (scaled >= 11'(6 * FULL_SCALE)) begin
      sec_nxt.sector = SEC_VTP;
      sec_nxt.rm     = 8'(scaled - 11'(6 * FULL_SCALE));
    end else if (scaled >= 11'(5 * FULL_SCALE)) begin
      sec_nxt.sector = SEC_VPQ;
      sec_nxt.rm     = 8'(scaled - 11'(5 * FULL_SCALE));
    end else if (scaled >= 11'(4 * FULL_SCALE)) begin
      sec_nxt.sector = SEC_TPV;
      sec_nxt.rm     = 8'(scaled - 11'(4 * FULL_SCALE));
    end else if (scaled >= 11'(3 * FULL_SCALE)) begin
      sec_nxt.sector = SEC_PQV;
      sec_nxt.rm     = 8'(scaled - 11'(3 * FULL_SCALE));
    end else if (scaled >= 11'(2 * FULL_SCALE)) begin
      sec_nxt.sector = SEC_PVT;
      sec_nxt.rm     = 8'(scaled - 11'(2 * FULL_SCALE));
    end else if (scaled >= 11'(FULL_SCALE)) begin
      sec_nxt.sector = SEC_QVP;
      sec_nxt.rm     = 8'(scaled - 11'(FULL_SCALE));
    end else begin
      sec_nxt.sector = SEC_VTP;
      sec_nxt.rm     = 8'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      sec_r <= sec_nxt;
    end
  end

endmodule

// ----- design/hsv2rgb_levels.sv -----
// Stages 2 to 6: computes the p, q and t levels with registered multiplies
// and shift-add divisions by 255. Depends on hsv2rgb_pkg.
module hsv2rgb_levels (
  input  logic                   clk,
  input  hsv2rgb_pkg::pipe_ctl_t ctl,
  input  hsv2rgb_pkg::sec_t      sec,
  output hsv2rgb_pkg::lvl_t      lvl_r
);
  import hsv2rgb_pkg::*;

  // stage 2: saturation products
  sector_t     s2_sector_r;
  logic [7:0]  s2_val_r;
  logic [15:0] s2_a_r, s2_b_r, s2_pp_r;
  // stage 3: complements, p done
  sector_t     s3_sector_r;
  logic [7:0]  s3_val_r, s3_p_r;
  logic [15:0] s3_qn_r, s3_tn_r;
  // stage 4: brightness products
  sector_t     s4_sector_r;
  logic [7:0]  s4_val_r, s4_p_r;
  logic [23:0] s4_qm_r, s4_tm_r;
  // stage 5: first divide by 255
  sector_t     s5_sector_r;
  logic [7:0]  s5_val_r, s5_p_r;
  logic [15:0] s5_q_r, s5_t_r;

  logic [16:0] p_full, q1_full, t1_full, q2_full, t2_full;

  always_comb begin
    p_full  = div255({8'b0, s2_pp_r});
    q1_full = div255(s4_qm_r);
    t1_full = div255(s4_tm_r);
    q2_full = div255({8'b0, s5_q_r});
    t2_full = div255({8'b0, s5_t_r});
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      s2_sector_r <= sec.sector;
      s2_val_r    <= sec.val;
      s2_a_r      <= {8'b0, sec.sat} * {8'b0, sec.rm};
      s2_b_r      <= {8'b0, sec.sat} * {8'b0, FULL_SCALE - sec.rm};
      s2_pp_r     <= {8'b0, sec.val} * {8'b0, FULL_SCALE - sec.sat};
    end
    if (ctl.adv[2]) begin
      s3_sector_r <= s2_sector_r;
      s3_val_r    <= s2_val_r;
      s3_p_r      <= p_full[7:0];
      s3_qn_r     <= FULL_SQUARE - s2_a_r;
      s3_tn_r     <= FULL_SQUARE - s2_b_r;
    end
    if (ctl.adv[3]) begin
      s4_sector_r <= s3_sector_r;
      s4_val_r    <= s3_val_r;
      s4_p_r      <= s3_p_r;
      s4_qm_r     <= {16'b0, s3_val_r} * {8'b0, s3_qn_r};
      s4_tm_r     <= {16'b0, s3_val_r} * {8'b0, s3_tn_r};
    end
    if (ctl.adv[4]) begin
      s5_sector_r <= s4_sector_r;
      s5_val_r    <= s4_val_r;
      s5_p_r      <= s4_p_r;
      s5_q_r      <= q1_full[15:0];
      s5_t_r      <= t1_full[15:0];
    end
    if (ctl.adv[5]) begin
      lvl_r.sector <= s5_sector_r;
      lvl_r.val    <= s5_val_r;
      lvl_r.p      <= s5_p_r;
      lvl_r.q      <= q2_full[7:0];
      lvl_r.t      <= t2_full[7:0];
    end
  end

endmodule

// ----- design/hsv2rgb_swizzle.sv -----
// Stage 7: places brightness and the p, q, t levels onto the color channels
// and holds the output register. Depends on hsv2rgb_pkg.
module hsv2rgb_swizzle (
  input  logic                   clk,
  input  hsv2rgb_pkg::pipe_ctl_t ctl,
  input  hsv2rgb_pkg::lvl_t      lvl,
  output logic [7:0]             red_r,
  output logic [7:0]             green_r,
  output logic [7:0]             blue_r
);
  import hsv2rgb_pkg::*;

  logic [7:0] red_nxt, green_nxt, blue_nxt;

  always_comb begin
    case (lvl.sector)
      SEC_QVP: begin
        red_nxt = lvl.q;   green_nxt = lvl.val; blue_nxt = lvl.p;
      end
      SEC_PVT: begin
        red_nxt = lvl.p;   green_nxt = lvl.val; blue_nxt = lvl.t;
      end
      SEC_PQV: begin
        red_nxt = lvl.p;   green_nxt = lvl.q;   blue_nxt = lvl.val;
      end
      SEC_TPV: begin
        red_nxt = lvl.t;   green_nxt = lvl.p;   blue_nxt = lvl.val;
      end
      SEC_VPQ: begin
        red_nxt = lvl.val; green_nxt = lvl.p;   blue_nxt = lvl.q;
      end
      default: begin
        red_nxt = lvl.val; green_nxt = lvl.t;   blue_nxt = lvl.p;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[STAGES-1]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

// ----- design/hsv_to_rgb_converter_core.sv -----
// HSV to RGB converter, 8 bits per channel, top level.
// Depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_levels, hsv2rgb_swizzle.
//
// Usage:
//   in_*  : one pixel per transfer, tdata = hue, saturation, brightness.
//   out_* : one pixel per transfer, tdata = red, green, blue.
//   Every input transfer yields exactly one output transfer, in order.
//   Path: each pixel passes through seven register stages, the last
//   one being the output register that drives out_tvalid and out_tdata.
//   Throughput: one pixel per cycle while the receiver is not stalling;
//   the two multiply and three divide-by-255 steps are each split across
//   their own stages.
//   Each stage advances when it is empty or the stage after it advances,
//   so bubbles are squeezed out and in_tready falls only when all seven
//   stages hold pixels and the receiver is stalling.
//   A stall holds out_tdata stable; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline; data registers
//   are not cleared.
module hsv_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] hue, [15:8] saturation, [23:16] brightness
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);
  import hsv2rgb_pkg::*;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  pipe_ctl_t         ctl;
  sec_t              sec;
  lvl_t              lvl;
  logic [7:0]        red, green, blue;

  always_comb begin
    ctl.adv[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      ctl.adv[k] = !vld_r[k] || ctl.adv[k+1];
    end
    vld_nxt[0] = ctl.adv[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_nxt[k] = ctl.adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = ctl.adv[0];
  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {blue, green, red};

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .ctl        (ctl),
    .hue        (in_tdata[7:0]),
    .saturation (in_tdata[15:8]),
    .brightness (in_tdata[23:16]),
    .sec_r      (sec)
  );

  hsv2rgb_levels u_levels (
    .clk   (clk),
    .ctl   (ctl),
    .sec   (sec),
    .lvl_r (lvl)
  );

  hsv2rgb_swizzle u_swizzle (
    .clk     (clk),
    .ctl     (ctl),
    .lvl     (lvl),
    .red_r   (red),
    .green_r (green),
    .blue_r  (blue)
  );

`ifndef SYNTHESIS
  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted pixel did not enter the first stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r) && !out_tready)
    else $error("input stalled while the pipeline had room");

  a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output changed or vanished");

  a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] && !in_tvalid |=> !vld_r[0] || $past(vld_r[0]))
    else $error("first stage became valid without a transfer");
`endif

endmodule
